// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the spanning tree edge selector RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk, off while rst is high.
`define ASSERT_AT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle is followed by another in the next.
`define ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/stsel_pkg.sv -----
// ----------------------------------------------------------------------------
// stsel_pkg
// Shared types and constants of the spanning tree edge selector.
// ----------------------------------------------------------------------------
package stsel_pkg;

  // Vertex numbers and the vertex count register are 7 bits wide.
  localparam int VTX_W = 7;
  localparam logic [VTX_W-1:0] VC_RESET = 7'd64;

  // Label memory command from the sequencer.
  typedef struct packed {
    logic rd;   // read one entry, data valid next cycle
    logic wr;   // write one entry
    logic clr;  // restore identity labels
  } mem_cmd_t;

  // Per-request result, without the weight.
  typedef struct packed {
    logic             chosen;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic             complete;
  } res_t;

endpackage

// ----- design/stsel_label_mem.sv -----
// ----------------------------------------------------------------------------
// stsel_label_mem
// Component label store: synchronous memory with one read port and one write
// port, plus a valid bit per entry. An entry that was not written since the
// last clear reads as its own index.
// ----------------------------------------------------------------------------
module stsel_label_mem #(
  parameter int MAX_VERTICES = 64,
  parameter int LBL_W        = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  stsel_pkg::mem_cmd_t  cmd,
  input  logic [LBL_W-1:0]     rd_addr,
  input  logic [LBL_W-1:0]     wr_addr,
  input  logic [LBL_W-1:0]     wr_data,
  output logic [LBL_W-1:0]     rd_label
);
  import stsel_pkg::*;

  logic [LBL_W-1:0]        mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vld;
  logic [LBL_W-1:0]        rd_data;
  logic [LBL_W-1:0]        rd_idx;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (cmd.clr) begin
      vld <= '0;
    end else if (cmd.wr) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
      rd_idx  <= rd_addr;
    end
  end

  assign rd_label = rd_vld ? rd_data : rd_idx;

endmodule

// ----- design/stsel_ctrl.sv -----
// ----------------------------------------------------------------------------
// stsel_ctrl
// Request sequencer: range check, reads of both end labels, compare, and the
// relabel sweep over the label memory. Holds the chosen edge count.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stsel_ctrl #(
  parameter int MAX_VERTICES = 64,
  parameter int LBL_W        = 6,
  parameter int CNT_W        = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [stsel_pkg::VTX_W-1:0] n,
  input  logic                        take_req,
  input  logic                        first_edge,
  input  logic [stsel_pkg::VTX_W-1:0] end_a,
  input  logic [stsel_pkg::VTX_W-1:0] end_b,
  input  logic                        out_free,
  output logic                        busy,
  output logic                        done,
  output stsel_pkg::res_t             res,
  output stsel_pkg::mem_cmd_t         cmd,
  output logic [LBL_W-1:0]            rd_addr,
  output logic [LBL_W-1:0]            wr_addr,
  output logic [LBL_W-1:0]            wr_data,
  input  logic [LBL_W-1:0]            rd_label
);
  import stsel_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_A, S_RD_B, S_CMP, S_SWEEP, S_DONE
  } state_t;

  state_t           state;
  logic [VTX_W-1:0] a_q;
  logic [VTX_W-1:0] b_q;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_v;
  logic [LBL_W-1:0] j;
  logic [LBL_W-1:0] la;
  logic [LBL_W-1:0] old_lbl;
  logic [LBL_W-1:0] new_lbl;
  logic             take;
  logic             eligible;
  logic             sweep_more;

  assign count_v    = first_edge ? '0 : count;
  assign eligible   = (int'(count_v) + 1 < int'(n))
                      && (end_a != '0) && (end_a <= n)
                      && (end_b != '0) && (end_b <= n);
  assign sweep_more = (int'(j) + 1 < int'(n));

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE) && out_free;

  always_comb begin
    res.chosen   = take;
    res.a        = a_q;
    res.b        = b_q;
    res.complete = (int'(count) + 1 >= int'(n));
  end

  always_comb begin
    cmd     = '0;
    rd_addr = '0;
    wr_addr = j;
    wr_data = new_lbl;
    case (state)
      S_IDLE: begin
        cmd.clr = take_req && first_edge;
      end
      S_RD_A: begin
        cmd.rd  = 1'b1;
        rd_addr = LBL_W'(a_q - VTX_W'(1));
      end
      S_RD_B: begin
        cmd.rd  = 1'b1;
        rd_addr = LBL_W'(b_q - VTX_W'(1));
      end
      S_CMP: begin
        // Prime the sweep with entry zero.
        cmd.rd = (la != rd_label);
      end
      S_SWEEP: begin
        cmd.wr  = (rd_label == old_lbl);
        cmd.rd  = sweep_more;
        rd_addr = j + LBL_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      take  <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (take_req) begin
            a_q   <= end_a;
            b_q   <= end_b;
            take  <= 1'b0;
            count <= count_v;
            state <= eligible ? S_RD_A : S_DONE;
          end
        end
        S_RD_A: begin
          state <= S_RD_B;
        end
        S_RD_B: begin
          la    <= rd_label;
          state <= S_CMP;
        end
        S_CMP: begin
          if (la != rd_label) begin
            take    <= 1'b1;
            count   <= count + CNT_W'(1);
            old_lbl <= (la > rd_label) ? la : rd_label;
            new_lbl <= (la < rd_label) ? la : rd_label;
            j       <= '0;
            state   <= S_SWEEP;
          end else begin
            state <= S_DONE;
          end
        end
        S_SWEEP: begin
          if (sweep_more) begin
            j <= j + LBL_W'(1);
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_AT(a_no_rw_same_entry, cmd.wr && cmd.rd |-> wr_addr != rd_addr, "read and write hit one entry")
  `ASSERT_AT(a_sweep_in_range, state == S_SWEEP |-> int'(j) < int'(n), "sweep ran past vertex count")
  `ASSERT_NEXT(a_chosen_counts, state == S_CMP && la != rd_label, int'(count) < int'(n), "chosen count overran vertex count")

endmodule

// ----- design/spanning_tree_edge_selector_top.sv -----
// ----------------------------------------------------------------------------
// spanning_tree_edge_selector_top
// Kruskal spanning tree edge selection over weight-sorted edges.
// ----------------------------------------------------------------------------
// Feed edges in ascending weight order, one request each; assert first_edge
// on the first edge of a graph to restore identity labels and clear the
// chosen count. Every request returns exactly one result: chosen is set when
// the two ends lie in different components, in which case out_weight carries
// tree_weight (otherwise zero) and the consumer writes it at both matrix
// positions. tree_complete rises once vertex_count-1 edges have been chosen;
// from then on every edge is refused. An edge with an end of zero or above
// the vertex count is refused and leaves the state alone. Component labels
// live in a synchronous memory with one read and one write port; choosing
// an edge sweeps all vertex_count entries, one per cycle, to merge the
// larger label into the smaller. A request refused up front goes from idle
// straight to done; any other reads both end labels and compares them, and
// a chosen edge adds the relabel sweep through the label memory. The
// next request is taken as soon as the result sits in the output register,
// even while the consumer still stalls it. The user must see that vertex_count
// is written only while the block is idle; the block does not enforce it.
// 0 acts as 1, values above MAX_VERTICES act as MAX_VERTICES.
// ----------------------------------------------------------------------------
module spanning_tree_edge_selector_top #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // vertex_count register write
  input  logic                        cfg_write,
  input  logic [stsel_pkg::VTX_W-1:0] cfg_data,
  // edge requests
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        first_edge,
  input  logic [stsel_pkg::VTX_W-1:0] end_a,
  input  logic [stsel_pkg::VTX_W-1:0] end_b,
  input  logic [WEIGHT_BITS-1:0]      tree_weight,
  // results
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        chosen,
  output logic [stsel_pkg::VTX_W-1:0] out_a,
  output logic [stsel_pkg::VTX_W-1:0] out_b,
  output logic [WEIGHT_BITS-1:0]      out_weight,
  output logic                        tree_complete
);
  import stsel_pkg::*;

  localparam int LBL_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES);

  logic [VTX_W-1:0]       vertex_count;
  logic [VTX_W-1:0]       n_eff;
  logic                   busy;
  logic                   take_req;
  logic                   done;
  logic                   out_free;
  logic [WEIGHT_BITS-1:0] weight_q;
  res_t                   res;
  mem_cmd_t               cmd;
  logic [LBL_W-1:0]       rd_addr;
  logic [LBL_W-1:0]       wr_addr;
  logic [LBL_W-1:0]       wr_data;
  logic [LBL_W-1:0]       rd_label;

  // Hold the vertex count register; reset to a full graph.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VC_RESET;
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  // Clamp the register into 1..MAX_VERTICES.
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = VTX_W'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_eff = VTX_W'(MAX_VERTICES);
    end else begin
      n_eff = vertex_count;
    end
  end

  // Take a new request whenever the sequencer is idle.
  assign in_stall = busy;
  assign take_req = in_valid && !in_stall;

  // The result register may be loaded when empty or draining this cycle.
  assign out_free = !out_valid || !out_stall;

  // Hold the weight of the request in flight.
  always_ff @(posedge clk) begin
    if (take_req) begin
      weight_q <= tree_weight;
    end
  end

  stsel_ctrl #(
    .MAX_VERTICES (MAX_VERTICES),
    .LBL_W        (LBL_W),
    .CNT_W        (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .n          (n_eff),
    .take_req   (take_req),
    .first_edge (first_edge),
    .end_a      (end_a),
    .end_b      (end_b),
    .out_free   (out_free),
    .busy       (busy),
    .done       (done),
    .res        (res),
    .cmd        (cmd),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_label   (rd_label)
  );

  stsel_label_mem #(
    .MAX_VERTICES (MAX_VERTICES),
    .LBL_W        (LBL_W)
  ) u_label_mem (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_label (rd_label)
  );

  // Result register: load on done, drop once the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      chosen        <= res.chosen;
      out_a         <= res.a;
      out_b         <= res.b;
      out_weight    <= res.chosen ? weight_q : '0;
      tree_complete <= res.complete;
    end
  end

endmodule

// ----- tb/edge_choice_monitor.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// edge_choice_monitor
// Watches the edge request and result channels of the spanning tree edge
// selector, predicts every result from its own copy of the component labels,
// the chosen count and the vertex count, and counts mismatches.
// ----------------------------------------------------------------------------
module edge_choice_monitor #(
  parameter int MAX_VERTICES = 64,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [stsel_pkg::VTX_W-1:0] cfg_data,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        first_edge,
  input  logic [stsel_pkg::VTX_W-1:0] end_a,
  input  logic [stsel_pkg::VTX_W-1:0] end_b,
  input  logic [WEIGHT_BITS-1:0]      tree_weight,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        chosen,
  input  logic [stsel_pkg::VTX_W-1:0] out_a,
  input  logic [stsel_pkg::VTX_W-1:0] out_b,
  input  logic [WEIGHT_BITS-1:0]      out_weight,
  input  logic                        tree_complete,
  output int                          outstanding,
  output int                          mismatches
);
  import stsel_pkg::*;

  typedef struct packed {
    res_t                   fields;
    logic [WEIGHT_BITS-1:0] weight;
  } edge_outcome_t;

  logic [VTX_W-1:0] label_of [MAX_VERTICES];
  int               joined_edges;
  logic [VTX_W-1:0] vertex_count;
  edge_outcome_t    pending_outcomes [$];

  function automatic void restore_identity();
    for (int i = 0; i < MAX_VERTICES; i++) label_of[i] = VTX_W'(i);
    joined_edges = 0;
  endfunction

  // Apply one edge request to the label state and return its result.
  function automatic edge_outcome_t predict_edge_choice(
    input logic                   first,
    input logic [VTX_W-1:0]       a,
    input logic [VTX_W-1:0]       b,
    input logic [WEIGHT_BITS-1:0] w
  );
    edge_outcome_t    v;
    int               n;
    int               ia;
    int               ib;
    logic [VTX_W-1:0] la;
    logic [VTX_W-1:0] lb;
    logic [VTX_W-1:0] keep;
    logic [VTX_W-1:0] drop;
    n  = (vertex_count == 0) ? 1 :
         (int'(vertex_count) > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
    ia = int'(a);
    ib = int'(b);
    if (first) restore_identity();
    v = '0;
    v.fields.a = a;
    v.fields.b = b;
    if (joined_edges < n - 1 && ia >= 1 && ia <= n && ib >= 1 && ib <= n) begin
      la = label_of[ia-1];
      lb = label_of[ib-1];
      if (la != lb) begin
        keep = (la < lb) ? la : lb;
        drop = (la < lb) ? lb : la;
        for (int j = 0; j < n; j++) begin
          if (label_of[j] == drop) label_of[j] = keep;
        end
        joined_edges++;
        v.fields.chosen = 1'b1;
        v.weight = w;
      end
    end
    v.fields.complete = (joined_edges >= n - 1);
    return v;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    edge_outcome_t want;
    if (rst) begin
      restore_identity();
      vertex_count = VC_RESET;
      pending_outcomes.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_write) vertex_count = cfg_data;
      // Retire the oldest expectation before queuing this edge's prediction.
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          $display("%0t: result with no request pending, expected none, actual a=%0d b=%0d",
                   $time, out_a, out_b);
        end else begin
          want = pending_outcomes.pop_front();
          check_field("chosen", 32'(want.fields.chosen), 32'(chosen));
          check_field("out_a", 32'(want.fields.a), 32'(out_a));
          check_field("out_b", 32'(want.fields.b), 32'(out_b));
          check_field("out_weight", 32'(want.weight), 32'(out_weight));
          check_field("tree_complete", 32'(want.fields.complete), 32'(tree_complete));
        end
      end
      if (in_valid && !in_stall)
        pending_outcomes.push_back(predict_edge_choice(first_edge, end_a, end_b,
                                                       tree_weight));
      outstanding <= pending_outcomes.size();
    end
  end

endmodule

// ----- tb/tb_spanning_tree_edge_selector_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spanning_tree_edge_selector_top
// Stimulus and verdict for the spanning tree edge selector.
// ----------------------------------------------------------------------------
// A short directed run covers extreme vertex numbers and weights, self loops,
// out-of-range ends, a completed tree, a single-vertex graph and vertex count
// changes while a tree is half built. Then random graphs follow, one vertex
// count setting per phase: each graph starts with first_edge and mostly
// grows a random spanning tree, mixed with redundant edges and noise. A
// separate monitor predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_spanning_tree_edge_selector_top;

  localparam int MAX_V    = 64;
  localparam int W_BITS   = 16;
  localparam int SETTLE   = MAX_V + 16;   // one full relabel sweep plus margin
  localparam int HOLD_LEN = 300;          // long output hold, in cycles

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic [stsel_pkg::VTX_W-1:0] cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        first_edge = 1'b0;
  logic [stsel_pkg::VTX_W-1:0] end_a = '0;
  logic [stsel_pkg::VTX_W-1:0] end_b = '0;
  logic [W_BITS-1:0]           tree_weight = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        chosen;
  logic [stsel_pkg::VTX_W-1:0] out_a;
  logic [stsel_pkg::VTX_W-1:0] out_b;
  logic [W_BITS-1:0]           out_weight;
  logic                        tree_complete;

  int outstanding;
  int mismatches;

  // Idle mix, long holds and progress, shared between the stimulus processes.
  int send_idle_pct = 34;
  int recv_idle_pct = 85;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int sent          = 0;
  int settings_used = 0;

  // Vertex count of each random phase: extremes, out-of-range codes, small
  // graphs for speed and a few full-size ones.
  int phase_vc [18] = '{4, 2, 64, 9, 1, 16, 100, 3, 0, 30, 7, 64, 12, 127, 5, 20, 6, 64};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  spanning_tree_edge_selector_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_edge   (first_edge),
    .end_a        (end_a),
    .end_b        (end_b),
    .tree_weight  (tree_weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen       (chosen),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_weight   (out_weight),
    .tree_complete(tree_complete)
  );

  edge_choice_monitor #(.MAX_VERTICES(MAX_V), .WEIGHT_BITS(W_BITS)) monitor (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .first_edge   (first_edge),
    .end_a        (end_a),
    .end_b        (end_b),
    .tree_weight  (tree_weight),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .chosen       (chosen),
    .out_a        (out_a),
    .out_b        (out_b),
    .out_weight   (out_weight),
    .tree_complete(tree_complete),
    .outstanding  (outstanding),
    .mismatches   (mismatches)
  );

  // Result consumer: stall at the current idle rate, or hold off for a long
  // stretch whenever the stimulus asks for one, counting the cycles here.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_asked > holds_done) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one edge request and return at the edge that accepts it. Valid
  // stays high on return; the next call either keeps it up or drops it for
  // an idle gap, so it gets a single assignment per step.
  task automatic offer_edge(input logic first, input int a, input int b,
                            input logic [W_BITS-1:0] w);
    int gap;
    // Swap the idle mix by progress: sender light / receiver heavy, then the
    // reverse, then no idling at all.
    if (sent < 650) begin
      send_idle_pct = 34;
      recv_idle_pct = 85;
    end else if (sent < 1300) begin
      send_idle_pct = 85;
      recv_idle_pct = 34;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    first_edge  <= first;
    end_a       <= a[stsel_pkg::VTX_W-1:0];
    end_b       <= b[stsel_pkg::VTX_W-1:0];
    tree_weight <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Drop valid and hold until every result is back and the block is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the vertex count; only call right after drain_results.
  task automatic set_vertex_count(input int vc);
    cfg_write <= 1'b1;
    cfg_data  <= vc[stsel_pkg::VTX_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // One graph: start with first_edge, grow a random spanning tree over a
  // shuffled vertex order, mixed with redundant edges, noise ends and the odd
  // stray first_edge, then a few edges after the tree is complete.
  task automatic send_graph(input int n);
    int               order [MAX_V];
    int               built;
    int               tail;
    int               roll;
    int               a;
    int               b;
    int               j;
    int               tmp;
    logic             first;
    logic [W_BITS-1:0] w;
    for (int k = 0; k < n; k++) order[k] = k + 1;
    for (int k = n - 1; k > 0; k--) begin
      j = $urandom_range(k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    built = 1;
    tail  = $urandom_range(4, 1);
    first = 1'b1;
    w     = W_BITS'($urandom_range(65535));
    while (built < n || tail > 0) begin
      roll = $urandom_range(99);
      if (built < n && roll < 60) begin
        a = order[built];
        b = order[$urandom_range(built - 1)];
        built++;
      end else begin
        if (roll < 90) begin
          a = $urandom_range(n, 1);
          b = $urandom_range(n, 1);
        end else begin
          a = $urandom_range(127);
          b = $urandom_range(127);
        end
        if (built >= n) tail--;
      end
      if ($urandom_range(1)) begin
        tmp = a;
        a = b;
        b = tmp;
      end
      if ($urandom_range(99) < 2) first = 1'b1;
      offer_edge(first, a, b, w);
      first = 1'b0;
      // Keep weights ascending, as a sorted edge list would arrive.
      w = w + W_BITS'($urandom_range(300));
    end
  endtask

  initial begin : stimulus
    int n;
    int phase_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part, vertex count at its reset value of 64.
    offer_edge(1'b1, 1, 64, 16'hFFFF);   // extreme ends, top weight: chosen
    offer_edge(1'b0, 64, 1, 16'h1234);   // same component now: refused
    offer_edge(1'b0, 5, 5, 16'h2000);    // self loop
    offer_edge(1'b0, 0, 3, 16'h2001);    // end of zero
    offer_edge(1'b0, 3, 65, 16'h2002);   // end just past the count
    offer_edge(1'b0, 127, 127, 16'h0);   // all-ones ends
    offer_edge(1'b0, 2, 3, 16'h0);       // chosen with zero weight
    offer_edge(1'b0, 1, 3, 16'h5555);    // merges two built components
    drain_results();

    // Shrink the count below what is already chosen: reads as complete.
    set_vertex_count(3);
    offer_edge(1'b0, 1, 2, 16'hAAAA);
    drain_results();

    // Count 0 acts as a single vertex: complete at once, all refused.
    set_vertex_count(0);
    offer_edge(1'b1, 1, 1, 16'h0101);
    offer_edge(1'b0, 1, 2, 16'h0102);
    drain_results();
    set_vertex_count(1);
    offer_edge(1'b1, 1, 2, 16'h0103);
    drain_results();

    // Count above the maximum acts as the maximum.
    set_vertex_count(127);
    offer_edge(1'b1, 64, 63, 16'h7FFF);
    offer_edge(1'b0, 1, 64, 16'h8000);
    drain_results();

    // Two vertices: one edge completes the tree, the next is refused without
    // a label check, and first_edge starts over.
    set_vertex_count(2);
    offer_edge(1'b1, 2, 1, 16'h00FF);
    offer_edge(1'b0, 1, 2, 16'hFF00);
    offer_edge(1'b1, 1, 2, 16'hF0F0);
    drain_results();

    // Random phases, one vertex count setting each.
    for (int p = 0; p < 18; p++) begin
      set_vertex_count(phase_vc[p]);
      n = (phase_vc[p] == 0) ? 1 : (phase_vc[p] > MAX_V) ? MAX_V : phase_vc[p];
      // Ask for a long output hold in each idle mix while requests keep
      // coming, so the block fills up and stalls its input.
      if (p == 2 || p == 8 || p == 14) holds_asked = holds_asked + 1;
      phase_start = sent;
      while (sent - phase_start < 100) send_graph(n);
      drain_results();
    end

    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d edge requests over %0d vertex count writes (0, 1, 2, 64, 127 and more),",
             sent, settings_used);
    $display("with three idle mixes and %0d long output holds.", holds_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/stsel_pkg.sv
design/stsel_label_mem.sv
design/stsel_ctrl.sv
design/spanning_tree_edge_selector_top.sv
tb/edge_choice_monitor.sv
tb/tb_spanning_tree_edge_selector_top.sv
